// ===== rtl/midi_tempo_detector_tap_defines.svh =====
// Assertion macros shared by the tempo detector RTL.
`ifndef MIDI_TEMPO_DETECTOR_TAP_DEFINES_SVH
`define MIDI_TEMPO_DETECTOR_TAP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MTDT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tempo detector assertion failed");

// Next-cycle implication, disabled during reset.
`define MTDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tempo detector assertion failed");

`endif

// ===== rtl/mtdt_pkg.sv =====
// Package: commands, MIDI codes, tempo constants and divider types.
`default_nettype none
package mtdt_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_MIDI  = 2'd1,
        CMD_TAP   = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    localparam logic [7:0] MIDI_SYSEX_START = 8'hF0;
    localparam logic [7:0] MIDI_SYSEX_END   = 8'hF7;
    localparam logic [7:0] MIDI_START       = 8'hFA;
    localparam logic [7:0] MIDI_CLOCK       = 8'hF8;
    localparam logic [3:0] MIDI_RT_NIBBLE   = 4'hF;

    localparam logic [7:0]  TICKS_PER_MEASURE = 8'd192;
    localparam logic [31:0] TAP_WINDOW        = 32'd400000;
    localparam logic [7:0]  CLOCK_BPM_MIN     = 8'd10;
    localparam logic [7:0]  CLOCK_BPM_MAX     = 8'd255;
    localparam logic [7:0]  TAP_BPM_MIN       = 8'd40;
    localparam logic [7:0]  TAP_BPM_MAX       = 8'd240;
    localparam logic [7:0]  RESET_TEMPO       = 8'd120;

    // Divider: 33-bit dividend, 32-bit divisor, one quotient bit per cycle.
    localparam int DIV_W     = 33;
    localparam int DEN_W     = 32;
    localparam int QUOT_W    = 8;
    localparam int DIV_STEPS = DIV_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [DIV_W-1:0] CLOCK_NUMERATOR = 33'd150000000;
    localparam logic [24:0]      TAP_NUMERATOR   = 25'd18750000;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;   // low quotient bits
        logic              ovf;    // quotient does not fit QUOT_W bits
    } t_div_rsp;

endpackage
`default_nettype wire

// ===== rtl/mtdt_in_if.sv =====
// Input channel interface: command and raw MIDI byte.
`default_nettype none
interface mtdt_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] midi_byte;

    modport source (output valid, output command, output midi_byte, input ready);
    modport sink   (input valid, input command, input midi_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/mtdt_out_if.sv =====
// Output channel interface: forwarded byte and tempo estimate.
`default_nettype none
interface mtdt_out_if;
    logic       valid;
    logic       ready;
    logic       forward_valid;
    logic [7:0] forward_byte;
    logic [7:0] tempo_bpm;
    logic       tempo_updated;
    logic       tempo_source;

    modport source (output valid, output forward_valid, output forward_byte,
                    output tempo_bpm, output tempo_updated, output tempo_source,
                    input ready);
    modport sink   (input valid, input forward_valid, input forward_byte,
                    input tempo_bpm, input tempo_updated, input tempo_source,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/mtdt_div.sv =====
// Bit-serial restoring divider with saturation flag on the quotient.
`default_nettype none
module mtdt_div
    import mtdt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_dvd;
    logic [DEN_W-1:0]     r_den;
    logic [QUOT_W-1:0]    r_quot;
    logic                 r_ovf;

    logic [DEN_W:0] w_trial;
    logic [DEN_W:0] w_diff;
    logic           w_ge;

    always_comb begin
        w_trial = {r_rem, r_dvd[DIV_W-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_dvd  <= i_req.num;
            r_den  <= i_req.den;
            r_quot <= '0;
            r_ovf  <= 1'b0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_dvd  <= {r_dvd[DIV_W-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
            r_ovf  <= r_ovf | r_quot[QUOT_W-1];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.ovf  = r_ovf;

endmodule
`default_nettype wire

// ===== rtl/midi_tempo_detector_tap.sv =====
// Top level: MIDI clock tempo detector with tap tempo.
// Flow from accept: items that compute no tempo go straight to DONE; a clock measurement
// or tap estimate goes through load, start, 33 divider steps and hand-off.
// The input takes no new item until the last one is handed to the output register; the
// bit-serial divider (one quotient bit per cycle over a 33-bit dividend) paces the divisions.
// Reset (synchronous, active low): counters and gap sum zero, tempo 120, no result.
`default_nettype none
`include "midi_tempo_detector_tap_defines.svh"
module midi_tempo_detector_tap
    import mtdt_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mtdt_in_if.sink    i_in,
    mtdt_out_if.source o_out
);

    // Sequencer: IDLE takes an item, LOAD kicks the divider, DIV waits for it,
    // DONE hands the result to the output register once that slot is free.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Architectural state
    logic [31:0] r_elapsed, n_elapsed;
    logic [7:0]  r_ticks,   n_ticks;
    logic [7:0]  r_taps,    n_taps;
    logic [31:0] r_gap_sum, n_gap_sum;
    logic [7:0]  r_tempo,   n_tempo;

    // Division operands, latched at accept
    logic [DIV_W-1:0] r_num, n_num;
    logic [DEN_W-1:0] r_den, n_den;
    logic             r_src_tap, n_src_tap;

    // Pending result fields
    logic       r_res_fwd,  n_res_fwd;
    logic [7:0] r_res_byte, n_res_byte;
    logic       r_res_upd,  n_res_upd;
    logic       r_res_src,  n_res_src;

    // Output register
    logic       r_out_valid, n_out_valid;
    logic       r_out_fwd;
    logic [7:0] r_out_byte;
    logic [7:0] r_out_tempo;
    logic       r_out_upd;
    logic       r_out_src;

    logic       w_accept;
    logic       w_xfer;
    logic [7:0] w_ticks_inc;
    logic [DIV_W-1:0] w_tap_prod;
    logic [31:0] w_sum_new;
    logic [7:0] w_clip;

    t_div_req w_req;
    t_div_rsp w_rsp;

    mtdt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_req.start = (r_state == S_LOAD);
    assign w_req.num   = r_num;
    assign w_req.den   = r_den;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    // Result moves to the output register when the slot is empty or being drained
    assign w_xfer     = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    assign w_ticks_inc = r_ticks + 8'd1;
    // taps are counted before the increment that this tap causes
    assign w_tap_prod  = DIV_W'(TAP_NUMERATOR) * {{(DIV_W-8){1'b0}}, r_taps};
    assign w_sum_new   = r_gap_sum + r_elapsed;

    // Clip the quotient; a zero divisor yields all ones, which clips to the upper bound.
    always_comb begin
        if (r_src_tap) begin
            if (w_rsp.ovf || (w_rsp.quot > TAP_BPM_MAX)) begin
                w_clip = TAP_BPM_MAX;
            end else if (w_rsp.quot < TAP_BPM_MIN) begin
                w_clip = TAP_BPM_MIN;
            end else begin
                w_clip = w_rsp.quot;
            end
        end else begin
            if (w_rsp.ovf || (w_rsp.quot > CLOCK_BPM_MAX)) begin
                w_clip = CLOCK_BPM_MAX;
            end else if (w_rsp.quot < CLOCK_BPM_MIN) begin
                w_clip = CLOCK_BPM_MIN;
            end else begin
                w_clip = w_rsp.quot;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_elapsed  = r_elapsed;
        n_ticks    = r_ticks;
        n_taps     = r_taps;
        n_gap_sum  = r_gap_sum;
        n_tempo    = r_tempo;
        n_num      = r_num;
        n_den      = r_den;
        n_src_tap  = r_src_tap;
        n_res_fwd  = r_res_fwd;
        n_res_byte = r_res_byte;
        n_res_upd  = r_res_upd;
        n_res_src  = r_res_src;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res_fwd  = 1'b0;
                    n_res_byte = 8'd0;
                    n_res_upd  = 1'b0;
                    n_res_src  = 1'b0;
                    n_state    = S_DONE;
                    case (t_cmd'(i_in.command))
                        CMD_TICK: begin
                            // saturating timer
                            if (r_elapsed != '1) begin
                                n_elapsed = r_elapsed + 32'd1;
                            end
                        end
                        CMD_MIDI: begin
                            // forward every byte outside F0-FF; the sysex delimiters F0 and F7 pass too
                            if ((i_in.midi_byte[7:4] != MIDI_RT_NIBBLE) ||
                                (i_in.midi_byte == MIDI_SYSEX_START) ||
                                (i_in.midi_byte == MIDI_SYSEX_END)) begin
                                n_res_fwd  = 1'b1;
                                n_res_byte = i_in.midi_byte;
                            end
                            if (i_in.midi_byte == MIDI_START) begin
                                n_ticks = 8'd0;
                            end
                            if (i_in.midi_byte == MIDI_CLOCK) begin
                                n_ticks = w_ticks_inc;
                                if (w_ticks_inc == TICKS_PER_MEASURE) begin
                                    // one full measure of clocks: measure tempo
                                    n_ticks   = 8'd0;
                                    n_elapsed = 32'd0;
                                    n_num     = CLOCK_NUMERATOR;
                                    n_den     = r_elapsed;
                                    n_src_tap = 1'b0;
                                    n_state   = S_LOAD;
                                end
                            end
                        end
                        CMD_TAP: begin
                            n_elapsed = 32'd0;
                            if ((r_taps != 8'd0) && (r_elapsed < TAP_WINDOW)) begin
                                n_gap_sum = w_sum_new;
                                n_num     = w_tap_prod;
                                n_den     = w_sum_new;
                                n_src_tap = 1'b1;
                                n_taps    = r_taps + 8'd1;
                                n_state   = S_LOAD;
                            end else begin
                                // gap too long or first tap: restart counting
                                n_gap_sum = 32'd0;
                                n_taps    = 8'd1;
                            end
                        end
                        CMD_CLEAR: begin
                            n_taps = 8'd0;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_rsp.done) begin
                    n_tempo   = w_clip;
                    n_res_upd = 1'b1;
                    n_res_src = r_src_tap;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (w_xfer) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_xfer) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_elapsed   <= 32'd0;
            r_ticks     <= 8'd0;
            r_taps      <= 8'd0;
            r_gap_sum   <= 32'd0;
            r_tempo     <= RESET_TEMPO;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_elapsed   <= n_elapsed;
            r_ticks     <= n_ticks;
            r_taps      <= n_taps;
            r_gap_sum   <= n_gap_sum;
            r_tempo     <= n_tempo;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_num      <= n_num;
        r_den      <= n_den;
        r_src_tap  <= n_src_tap;
        r_res_fwd  <= n_res_fwd;
        r_res_byte <= n_res_byte;
        r_res_upd  <= n_res_upd;
        r_res_src  <= n_res_src;
        if (w_xfer) begin
            r_out_fwd   <= r_res_fwd;
            r_out_byte  <= r_res_byte;
            r_out_tempo <= r_tempo;
            r_out_upd   <= r_res_upd;
            r_out_src   <= r_res_src;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.forward_valid = r_out_fwd;
    assign o_out.forward_byte  = r_out_byte;
    assign o_out.tempo_bpm     = r_out_tempo;
    assign o_out.tempo_updated = r_out_upd;
    assign o_out.tempo_source  = r_out_src;

    // An accepted item always blocks the input for the next cycle
    `MTDT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !i_in.ready)
    // The divider only reports while the sequencer waits for it
    `MTDT_ASSERT_SAME(a_div_done_in_div, i_clk, i_rst_n, w_rsp.done, r_state == S_DIV)
    // A handed-off result shows up as a valid output item
    `MTDT_ASSERT_NEXT(a_xfer_to_out, i_clk, i_rst_n, w_xfer, r_out_valid)

endmodule
`default_nettype wire
